// ===== hdl/pcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants for the pattern compile and table match core.
// ----------------------------------------------------------------------------
package pcm_pkg;

  // Number of entries in the transition table.
  localparam int TableDepth = 128;

  // Table address width and width of counts and state numbers.
  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW  = ($clog2(TableDepth + 1) > 8) ? $clog2(TableDepth + 1) : 8;
  localparam int SymW  = 8;

  // Operator characters of the pattern language.
  localparam logic [SymW-1:0] ChStar = 8'h2A;
  localparam logic [SymW-1:0] ChPlus = 8'h2B;
  localparam logic [SymW-1:0] ChBar  = 8'h7C;

  // Stream selector codes.
  localparam logic FuncPattern = 1'b0;
  localparam logic FuncSubject = 1'b1;

  // One transition entry.
  typedef struct packed {
    logic [CntW-1:0] src;
    logic [SymW-1:0] sym;
    logic [CntW-1:0] dst;
  } edge_t;

  localparam int EdgeW = $bits(edge_t);

  // Table write port.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    edge_t            data;
  } tbl_wr_t;

  // Table read request.
  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] addr;
  } tbl_rd_t;

endpackage

// ===== hdl/pcm_if.sv =====
// ----------------------------------------------------------------------------
// pcm_if
// Valid/ready channels for character words and result words.
// ----------------------------------------------------------------------------
interface pcm_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output func, output ch, output last, input ready);
  modport sink   (input valid, input func, input ch, input last, output ready);
endinterface

interface pcm_out_if;
  logic       valid;
  logic       ready;
  logic       done_res;
  logic       accepted;
  logic [7:0] entry_count;
  logic [7:0] accept_state;
  logic       overflow;

  modport source (output valid, output done_res, output accepted, output entry_count,
                  output accept_state, output overflow, input ready);
  modport sink   (input valid, input done_res, input accepted, input entry_count,
                  input accept_state, input overflow, output ready);
endinterface

// ===== hdl/pcm_ram.sv =====
// ----------------------------------------------------------------------------
// pcm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcm_ram #(
  parameter int Depth = 128,
  parameter int Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/pcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcm_ctrl
// Sequencer that compiles pattern characters into table entries and walks
// the table for subject characters.
// ----------------------------------------------------------------------------
module pcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcm_in_if.sink            in_i,
  pcm_out_if.source         out_o,
  output pcm_pkg::tbl_wr_t  wr_o,
  output pcm_pkg::tbl_rd_t  rd_o,
  input  pcm_pkg::edge_t    rdata_i
);

  localparam int AddrW = pcm_pkg::AddrW;
  localparam int CntW  = pcm_pkg::CntW;
  localparam int SymW  = pcm_pkg::SymW;
  localparam logic [CntW-1:0] DepthC = CntW'(pcm_pkg::TableDepth);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWr   = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;

  logic [2:0] state_q, state_d;

  // Block state.
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] bp_q, bp_d;
  logic [CntW-1:0] goal_q, goal_d;
  logic [SymW-1:0] hc_q, hc_d;
  logic            hv_q, hv_d;
  logic            in_pat_q, in_pat_d;
  logic [CntW-1:0] ws_q, ws_d;
  logic            dead_q, dead_d;
  logic            in_sub_q, in_sub_d;
  logic            ovf_q, ovf_d;

  // Item in flight.
  logic [SymW-1:0]      ch_q, ch_d;
  logic                 last_q, last_d;
  logic                 func_q, func_d;
  logic [1:0]           pend_q, pend_d;
  pcm_pkg::edge_t       e0_q, e0_d, e1_q, e1_d;
  logic [CntW-1:0]      issue_q, issue_d;
  logic                 rv_q, rv_d;

  // Result register.
  logic            ovld_q, ovld_d;
  logic            odone_q, odone_d;
  logic            oacc_q, oacc_d;
  logic [7:0]      ocnt_q, ocnt_d;
  logic [7:0]      ogoal_q, ogoal_d;
  logic            oovf_q, oovf_d;

  // Pattern decode helpers.
  logic            in_acc;
  logic            is_op;
  logic [CntW-1:0] bp0, bp1, nx0, nx1;
  logic            hv0, hv1;
  logic [SymW-1:0] hc1;
  logic [1:0]      n_e;
  pcm_pkg::edge_t  pe0, pe1, end_e;
  logic            hit;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);
  assign is_op = (in_i.ch == pcm_pkg::ChStar) || (in_i.ch == pcm_pkg::ChPlus) ||
                 (in_i.ch == pcm_pkg::ChBar);

  // Edges produced by one pattern character, at most two.
  always_comb begin
    bp0   = in_pat_q ? bp_q : '0;
    hv0   = in_pat_q ? hv_q : 1'b0;
    nx0   = (bp0 < DepthC) ? bp0 + 1'b1 : bp0;
    n_e   = 2'd0;
    pe0   = '0;
    pe1   = '0;
    bp1   = bp0;
    hv1   = hv0;
    hc1   = hc_q;
    if (hv0) begin
      hv1 = 1'b0;
      if (in_i.ch == pcm_pkg::ChStar) begin
        pe0 = '{src: bp0, sym: hc_q, dst: bp0};
        n_e = 2'd1;
      end else if (in_i.ch == pcm_pkg::ChPlus) begin
        pe0 = '{src: bp0, sym: hc_q, dst: nx0};
        pe1 = '{src: nx0, sym: hc_q, dst: nx0};
        n_e = 2'd2;
        bp1 = nx0;
      end else begin
        pe0 = '{src: bp0, sym: hc_q, dst: nx0};
        n_e = 2'd1;
        bp1 = nx0;
        if (!is_op) begin
          hc1 = in_i.ch;
          hv1 = 1'b1;
        end
      end
    end else if (!is_op) begin
      hc1 = in_i.ch;
      hv1 = 1'b1;
    end
    nx1   = (bp1 < DepthC) ? bp1 + 1'b1 : bp1;
    end_e = '{src: bp1, sym: hc1, dst: nx1};
  end

  assign hit = (rdata_i.src == ws_q) && (rdata_i.sym == ch_q);

  // Main sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bp_d     = bp_q;
    goal_d   = goal_q;
    hc_d     = hc_q;
    hv_d     = hv_q;
    in_pat_d = in_pat_q;
    ws_d     = ws_q;
    dead_d   = dead_q;
    in_sub_d = in_sub_q;
    ovf_d    = ovf_q;
    ch_d     = ch_q;
    last_d   = last_q;
    func_d   = func_q;
    pend_d   = pend_q;
    e0_d     = e0_q;
    e1_d     = e1_q;
    issue_d  = issue_q;
    rv_d     = 1'b0;
    ovld_d   = ovld_q && !out_o.ready;
    odone_d  = odone_q;
    oacc_d   = oacc_q;
    ocnt_d   = ocnt_q;
    ogoal_d  = ogoal_q;
    oovf_d   = oovf_q;
    wr_o     = '0;
    rd_o     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          ch_d   = in_i.ch;
          last_d = in_i.last;
          func_d = in_i.func;
          if (in_i.func == pcm_pkg::FuncPattern) begin
            // A new pattern clears the table and the overflow flag.
            if (!in_pat_q) begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            e0_d   = pe0;
            e1_d   = pe1;
            pend_d = n_e;
            hc_d   = hc1;
            if (in_i.last) begin
              if (hv1) begin
                if (n_e == 2'd0) begin
                  e0_d = end_e;
                end else begin
                  e1_d = end_e;
                end
                pend_d = n_e + 2'd1;
                bp_d   = nx1;
                goal_d = nx1;
              end else begin
                bp_d   = bp1;
                goal_d = bp1;
              end
              hv_d     = 1'b0;
              in_pat_d = 1'b0;
            end else begin
              bp_d     = bp1;
              hv_d     = hv1;
              in_pat_d = 1'b1;
            end
            state_d = ((n_e != 2'd0) || (in_i.last && hv1)) ? StWr : StFin;
          end else begin
            // A new subject restarts the walk at state zero.
            ws_d     = in_sub_q ? ws_q : '0;
            dead_d   = in_sub_q ? dead_q : 1'b0;
            in_sub_d = !in_i.last;
            issue_d  = '0;
            if (in_sub_q && dead_q) begin
              state_d = StFin;
            end else if (cnt_q == '0) begin
              dead_d  = 1'b1;
              state_d = StFin;
            end else begin
              state_d = StScan;
            end
          end
        end
      end

      StWr: begin
        // One table write per cycle; a full table drops the entry.
        if (cnt_q < DepthC) begin
          wr_o.we   = 1'b1;
          wr_o.addr = cnt_q[AddrW-1:0];
          wr_o.data = e0_q;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        e0_d   = e1_q;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          state_d = StFin;
        end
      end

      StScan: begin
        // Reads are issued one a cycle; the data is checked in the cycle after.
        if (rv_q && hit) begin
          ws_d    = rdata_i.dst;
          state_d = StFin;
        end else if (rv_q && (issue_q == cnt_q)) begin
          dead_d  = 1'b1;
          state_d = StFin;
        end else if (issue_q < cnt_q) begin
          rd_o.re   = 1'b1;
          rd_o.addr = issue_q[AddrW-1:0];
          issue_d   = issue_q + 1'b1;
          rv_d      = 1'b1;
        end
      end

      StFin: begin
        // Load the result word once the output register is free.
        if (!ovld_q || out_o.ready) begin
          ovld_d  = 1'b1;
          odone_d = last_q;
          oacc_d  = (func_q == pcm_pkg::FuncSubject) && last_q && !dead_q &&
                    (ws_q == goal_q);
          ocnt_d  = cnt_q[7:0];
          ogoal_d = goal_q[7:0];
          oovf_d  = ovf_q;
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      bp_q     <= '0;
      goal_q   <= '0;
      hc_q     <= '0;
      hv_q     <= 1'b0;
      in_pat_q <= 1'b0;
      ws_q     <= '0;
      dead_q   <= 1'b0;
      in_sub_q <= 1'b0;
      ovf_q    <= 1'b0;
      pend_q   <= '0;
      issue_q  <= '0;
      rv_q     <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      bp_q     <= bp_d;
      goal_q   <= goal_d;
      hc_q     <= hc_d;
      hv_q     <= hv_d;
      in_pat_q <= in_pat_d;
      ws_q     <= ws_d;
      dead_q   <= dead_d;
      in_sub_q <= in_sub_d;
      ovf_q    <= ovf_d;
      pend_q   <= pend_d;
      issue_q  <= issue_d;
      rv_q     <= rv_d;
      ovld_q   <= ovld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    last_q  <= last_d;
    func_q  <= func_d;
    e0_q    <= e0_d;
    e1_q    <= e1_d;
    odone_q <= odone_d;
    oacc_q  <= oacc_d;
    ocnt_q  <= ocnt_d;
    ogoal_q <= ogoal_d;
    oovf_q  <= oovf_d;
  end

  assign out_o.valid        = ovld_q;
  assign out_o.done_res     = odone_q;
  assign out_o.accepted     = oacc_q;
  assign out_o.entry_count  = ocnt_q;
  assign out_o.accept_state = ogoal_q;
  assign out_o.overflow     = oovf_q;

  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DepthC)
    else $error("entry count beyond table depth");

  // No table write happens while the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_o.we |-> (cnt_q < DepthC))
    else $error("table write past the last entry");

  // The scan never reads beyond the held entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_o.re |-> (issue_q < cnt_q))
    else $error("scan read beyond entry count");

  // Writes and reads of the table never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_o.we && rd_o.re))
    else $error("table read and write in one cycle");

  // The build position saturates at the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bp_q <= DepthC)
    else $error("build position beyond table depth");

endmodule

// ===== hdl/pattern_compile_and_table_match_core.sv =====
// ----------------------------------------------------------------------------
// pattern_compile_and_table_match_core
// Compiles pattern characters into a transition table and matches subject
// characters against it, one result word per character word.
//
//   Channel   Direction   Words
//   in_i      sink        func, ch, last
//   out_o     source      done_res, accepted, entry_count, accept_state, overflow
//
// A pattern word is decoded on acceptance; StWr then writes its table entries
// and StFin loads its result word. A subject word is scanned in StScan, which
// reads one table entry per cycle until a hit or the last held entry.
// Reset clears all control state; table contents need no clearing.
// A finished result waits in the output register while the next word is
// accepted; a stalled output only holds the sequencer at its last step.
// ----------------------------------------------------------------------------
module pattern_compile_and_table_match_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcm_in_if.sink    in_i,
  pcm_out_if.source out_o
);

  pcm_pkg::tbl_wr_t wr;
  pcm_pkg::tbl_rd_t rd;
  pcm_pkg::edge_t   rdata;
  logic [pcm_pkg::EdgeW-1:0] rdata_raw;

  // Sequencer.
  pcm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .wr_o    (wr),
    .rd_o    (rd),
    .rdata_i (rdata)
  );

  // Transition table.
  pcm_ram #(
    .Depth (pcm_pkg::TableDepth),
    .Width (pcm_pkg::EdgeW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (rdata_raw)
  );

  assign rdata = pcm_pkg::edge_t'(rdata_raw);

endmodule

// ===== bench/pattern_compile_and_table_match_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_compile_and_table_match_core_tb
// Self-checking bench for the pattern compile and table match core. Pattern
// words build the shared transition table and subject words walk it. A short
// table of directed words comes first, followed by random patterns and by
// subjects shaped from the last closed pattern. Every result word is checked
// against an in-bench model of the table, with random stalls on both sides.
// ----------------------------------------------------------------------------
module pattern_compile_and_table_match_core_tb;

  localparam int RandomWords = 1100;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 3000;
  localparam int TailCycles  = 140;

  // One character word and one result word.
  typedef struct packed {
    logic       func;
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic       done_res;
    logic       accepted;
    logic [7:0] entry_count;
    logic [7:0] accept_state;
    logic       overflow;
  } match_res_t;

  // A directed row: the word, and a typed-in result where one is given.
  typedef struct packed {
    char_word_t w;
    logic       typed;
    match_res_t r;
  } plan_row_t;

  // Operator that follows a literal in a generated pattern.
  typedef enum logic [1:0] {
    OpNone,
    OpStar,
    OpPlus,
    OpBar
  } post_op_e;

  typedef struct packed {
    logic [7:0] lit;
    post_op_e   op;
  } token_t;

  logic clk_i;
  logic rst_ni;

  pcm_in_if  in_if ();
  pcm_out_if out_if ();

  pattern_compile_and_table_match_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Model of the table and of both stream states.
  pcm_pkg::edge_t rule_tbl [pcm_pkg::TableDepth];
  logic [7:0] rule_cnt;
  logic [7:0] tail_state;
  logic [7:0] goal_mark;
  logic [7:0] held_sym;
  logic       held_ok;
  logic       pat_open;
  logic [7:0] cursor;
  logic       walk_lost;
  logic       subj_open;
  logic       dropped;

  match_res_t result_words_due [$];
  token_t     last_shape [$];

  int  words_sent;
  int  words_checked;
  int  fail_count;
  int  patterns_closed;
  int  overflow_runs;
  int  subjects_closed;
  int  subjects_hit;
  logic calm;

  // A long stretch in the middle of the run with no idling on either side.
  assign calm = (words_sent >= 420) && (words_sent < 580);

  function automatic logic is_op(input logic [7:0] c);
    return c == pcm_pkg::ChStar || c == pcm_pkg::ChPlus || c == pcm_pkg::ChBar;
  endfunction

  function automatic logic [7:0] next_state();
    return (tail_state < pcm_pkg::TableDepth) ? tail_state + 8'd1 : tail_state;
  endfunction

  function automatic void bump_state();
    if (tail_state < pcm_pkg::TableDepth) tail_state = tail_state + 8'd1;
  endfunction

  // Append a transition, or flag the drop when the table is full.
  function automatic void add_rule(input logic [7:0] src, input logic [7:0] sym,
                                   input logic [7:0] dst);
    if (rule_cnt >= pcm_pkg::TableDepth) begin
      dropped = 1'b1;
    end else begin
      rule_tbl[rule_cnt[pcm_pkg::AddrW-1:0]] = '{src, sym, dst};
      rule_cnt = rule_cnt + 8'd1;
    end
  endfunction

  // Apply one accepted word to the model and return the result word it owes.
  function automatic match_res_t compile_or_walk(input char_word_t w);
    match_res_t r;
    logic [7:0] nx;
    logic       moved;
    r = '0;
    if (w.func == pcm_pkg::FuncPattern) begin
      if (!pat_open) begin
        pat_open   = 1'b1;
        rule_cnt   = '0;
        tail_state = '0;
        held_ok    = 1'b0;
        dropped    = 1'b0;
      end
      if (held_ok) begin
        held_ok = 1'b0;
        if (w.ch == pcm_pkg::ChStar) begin
          add_rule(tail_state, held_sym, tail_state);
        end else if (w.ch == pcm_pkg::ChPlus) begin
          nx = next_state();
          add_rule(tail_state, held_sym, nx);
          add_rule(nx, held_sym, nx);
          bump_state();
        end else begin
          // A bar or a new literal closes the held literal as a plain step.
          add_rule(tail_state, held_sym, next_state());
          bump_state();
          if (!is_op(w.ch)) begin
            held_sym = w.ch;
            held_ok  = 1'b1;
          end
        end
      end else if (!is_op(w.ch)) begin
        held_sym = w.ch;
        held_ok  = 1'b1;
      end
      if (w.last) begin
        if (held_ok) begin
          add_rule(tail_state, held_sym, next_state());
          bump_state();
          held_ok = 1'b0;
        end
        goal_mark  = tail_state;
        pat_open   = 1'b0;
        r.done_res = 1'b1;
        patterns_closed++;
        if (dropped) overflow_runs++;
      end
    end else begin
      if (!subj_open) begin
        subj_open = 1'b1;
        cursor    = '0;
        walk_lost = 1'b0;
      end
      // First matching entry wins.
      if (!walk_lost) begin
        moved = 1'b0;
        for (int j = 0; j < pcm_pkg::TableDepth; j++) begin
          if (!moved && j < rule_cnt && rule_tbl[j].src == cursor &&
              rule_tbl[j].sym == w.ch) begin
            cursor = rule_tbl[j].dst;
            moved  = 1'b1;
          end
        end
        if (!moved) walk_lost = 1'b1;
      end
      if (w.last) begin
        r.done_res = 1'b1;
        r.accepted = !walk_lost && cursor == goal_mark;
        subj_open  = 1'b0;
        subjects_closed++;
        if (r.accepted) subjects_hit++;
      end
    end
    r.entry_count  = rule_cnt;
    r.accept_state = goal_mark;
    r.overflow     = dropped;
    return r;
  endfunction

  // Directed words: empty table, lone operators, zero byte, star, plus, bar,
  // interleaved streams, a subject miss, and the byte extremes.
  plan_row_t plan [25] = '{
    '{'{pcm_pkg::FuncSubject, 8'h61, 1'b1}, 1'b1, '{1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChBar, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChStar, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChPlus, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{pcm_pkg::FuncPattern, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChStar, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'd1, 8'd0, 1'b0}},
    '{'{pcm_pkg::FuncSubject, 8'h00, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, 8'h62, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChPlus, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, 8'h63, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChBar, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, 8'hFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 8'd5, 8'd3, 1'b0}},
    '{'{pcm_pkg::FuncSubject, 8'h62, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'h62, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'h63, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'hFF, 1'b1}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'h7F, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'h62, 1'b1}, 1'b1, '{1'b1, 1'b0, 8'd5, 8'd3, 1'b0}},
    '{'{pcm_pkg::FuncPattern, 8'h78, 1'b1}, 1'b1, '{1'b1, 1'b0, 8'd1, 8'd1, 1'b0}},
    '{'{pcm_pkg::FuncSubject, 8'h78, 1'b1}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, 8'h71, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncPattern, pcm_pkg::ChPlus, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 8'd2, 8'd1, 1'b0}},
    '{'{pcm_pkg::FuncSubject, 8'h71, 1'b0}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'h71, 1'b1}, 1'b0, '0},
    '{'{pcm_pkg::FuncSubject, 8'h80, 1'b1}, 1'b1, '{1'b1, 1'b0, 8'd2, 8'd1, 1'b0}}
  };

  // Mostly a small alphabet so that subjects find their way; now and then
  // any byte, including the extremes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'h61 + 8'($urandom_range(3));
    if (r < 95) return 8'($urandom);
    return (r < 97) ? 8'h00 : 8'hFF;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(2))
      0:       return pcm_pkg::ChStar;
      1:       return pcm_pkg::ChPlus;
      default: return pcm_pkg::ChBar;
    endcase
  endfunction

  // Offer one word; on acceptance, record the result word it owes.
  task automatic send_word(input char_word_t w, input logic typed, input match_res_t want);
    match_res_t model_res;
    if (!calm && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= w.func;
    in_if.ch    <= w.ch;
    in_if.last  <= w.last;
    do @(posedge clk_i); while (!in_if.ready);
    model_res = compile_or_walk(w);
    result_words_due.push_back(typed ? want : model_res);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_all(ref char_word_t words [$]);
    foreach (words[i]) send_word(words[i], 1'b0, '0);
  endtask

  // Build a pattern from random tokens and remember its shape for subjects.
  task automatic build_pattern(input int n_tok, input logic long_form,
                               ref char_word_t words [$]);
    token_t tok;
    int     r;
    words.delete();
    last_shape.delete();
    if ($urandom_range(9) == 0)
      words.push_back(char_word_t'{pcm_pkg::FuncPattern, pick_op(), 1'b0});
    for (int i = 0; i < n_tok; i++) begin
      r       = $urandom_range(99);
      tok.lit = long_form ? 8'h61 + 8'($urandom_range(3)) : pick_char();
      if (long_form) tok.op = (r < 10) ? OpPlus : OpNone;
      else if (r < 50) tok.op = OpNone;
      else if (r < 65) tok.op = OpStar;
      else if (r < 80) tok.op = OpPlus;
      else if (r < 90) tok.op = OpBar;
      else tok.op = OpNone;
      last_shape.push_back(tok);
      words.push_back(char_word_t'{pcm_pkg::FuncPattern, tok.lit, 1'b0});
      case (tok.op)
        OpStar:  words.push_back(char_word_t'{pcm_pkg::FuncPattern, pcm_pkg::ChStar, 1'b0});
        OpPlus:  words.push_back(char_word_t'{pcm_pkg::FuncPattern, pcm_pkg::ChPlus, 1'b0});
        OpBar:   words.push_back(char_word_t'{pcm_pkg::FuncPattern, pcm_pkg::ChBar, 1'b0});
        default: ;
      endcase
    end
    words[words.size()-1].last = 1'b1;
  endtask

  // A subject that follows the last pattern's shape, sometimes damaged, or
  // plain noise.
  task automatic build_subject(input logic noisy, ref char_word_t words [$]);
    int reps;
    words.delete();
    if (noisy || last_shape.size() == 0) begin
      repeat ($urandom_range(1, 6))
        words.push_back(char_word_t'{pcm_pkg::FuncSubject, pick_char(), 1'b0});
    end else begin
      foreach (last_shape[i]) begin
        case (last_shape[i].op)
          OpStar:  reps = $urandom_range(0, 2);
          OpPlus:  reps = $urandom_range(1, 3);
          default: reps = 1;
        endcase
        repeat (reps)
          words.push_back(char_word_t'{pcm_pkg::FuncSubject, last_shape[i].lit, 1'b0});
      end
      if (words.size() != 0 && $urandom_range(4) == 0)
        words[$urandom_range(words.size()-1)].ch = pick_char();
      if (words.size() > 1 && $urandom_range(9) == 0) void'(words.pop_back());
      if ($urandom_range(9) == 0)
        words.push_back(char_word_t'{pcm_pkg::FuncSubject, pick_char(), 1'b0});
    end
    if (words.size() == 0)
      words.push_back(char_word_t'{pcm_pkg::FuncSubject, pick_char(), 1'b0});
    words[words.size()-1].last = 1'b1;
  endtask

  // Stimulus, drain and verdict.
  initial begin
    char_word_t pat_q [$];
    char_word_t subj_q [$];
    char_word_t mix_q [$];
    int         seq_no;
    int         r;
    in_if.valid = 1'b0;
    in_if.func  = pcm_pkg::FuncPattern;
    in_if.ch    = '0;
    in_if.last  = 1'b0;
    rst_ni      = 1'b0;
    cursor      = '0;
    rule_cnt    = '0;
    tail_state  = '0;
    goal_mark   = '0;
    held_sym    = '0;
    held_ok     = 1'b0;
    pat_open    = 1'b0;
    walk_lost   = 1'b0;
    subj_open   = 1'b0;
    dropped     = 1'b0;
    seq_no      = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].r);

    // Random sequences; two long patterns fill the table past its end.
    while (words_sent < $size(plan) + RandomWords) begin
      r = $urandom_range(99);
      if (seq_no == 3 || seq_no == 90) begin
        build_pattern($urandom_range(130, 136), 1'b1, pat_q);
        send_all(pat_q);
      end else if (r < 30) begin
        build_pattern($urandom_range(1, 8), 1'b0, pat_q);
        send_all(pat_q);
      end else if (r < 75) begin
        build_subject(1'b0, subj_q);
        send_all(subj_q);
      end else if (r < 88) begin
        build_subject(1'b1, subj_q);
        send_all(subj_q);
      end else begin
        // Interleave a subject with a new pattern, each in its own order.
        build_subject(1'b0, subj_q);
        build_pattern($urandom_range(1, 6), 1'b0, pat_q);
        mix_q.delete();
        while (pat_q.size() != 0 || subj_q.size() != 0) begin
          if (subj_q.size() == 0 || (pat_q.size() != 0 && $urandom_range(1) == 0))
            mix_q.push_back(pat_q.pop_front());
          else
            mix_q.push_back(subj_q.pop_front());
        end
        send_all(mix_q);
      end
      seq_no++;
    end
    in_if.valid <= 1'b0;

    while (result_words_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d patterns (%0d with a full table)", patterns_closed,
             overflow_runs);
    $display("and %0d subjects (%0d accepted); %0d character words sent, %0d checked.",
             subjects_closed, subjects_hit, words_sent, words_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output ready: random stalls, one long hold-off while the input keeps
  // offering, and the calm stretch with no stalls.
  initial begin
    logic held;
    held         = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && words_sent >= 250) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_if.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // Compare each result word with the oldest one owed.
  always @(posedge clk_i) begin
    match_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_checked++;
      if (result_words_due.size() == 0) begin
        $error("result word with none expected");
        fail_count++;
      end else begin
        want = result_words_due.pop_front();
        if (out_if.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_if.done_res);
          fail_count++;
        end
        if (out_if.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_if.accepted);
          fail_count++;
        end
        if (out_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_if.entry_count);
          fail_count++;
        end
        if (out_if.accept_state !== want.accept_state) begin
          $error("accept_state: expected %0d, got %0d", want.accept_state,
                 out_if.accept_state);
          fail_count++;
        end
        if (out_if.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_if.overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either side.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no word moved for %0d cycles.", IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pcm_pkg.sv
hdl/pcm_if.sv
hdl/pcm_ram.sv
hdl/pcm_ctrl.sv
hdl/pattern_compile_and_table_match_core.sv
bench/pattern_compile_and_table_match_core_tb.sv
